### hw/rtl/spb_pkg.sv
`default_nettype none
package spb_pkg;
  localparam int NAME_BYTES_DEF = 16;

  localparam logic [7:0] ACK_BYTE = 8'h06;
  localparam logic [7:0] NAK_BYTE = 8'h15;

  localparam logic [2:0] DST_HOST  = 3'd0;
  localparam logic [2:0] DST_WRITE = 3'd1;
  localparam logic [2:0] DST_REQ   = 3'd2;
  localparam logic [2:0] DST_SEL   = 3'd3;
  localparam logic [2:0] DST_DESEL = 3'd4;
  localparam logic [2:0] DST_HOLD  = 3'd5;
  localparam logic [2:0] DST_PULSE = 3'd6;

  // reply kinds handed from the parser to the emitter
  localparam logic [3:0] JOB_NONE   = 4'd0;
  localparam logic [3:0] JOB_ONE    = 4'd1;  // single result, d0/b0 given
  localparam logic [3:0] JOB_TWO    = 4'd2;  // two results, d0/b0 then d1/b1
  localparam logic [3:0] JOB_IFACE  = 4'd3;
  localparam logic [3:0] JOB_MAP    = 4'd4;
  localparam logic [3:0] JOB_NAME   = 4'd5;
  localparam logic [3:0] JOB_BUF    = 4'd6;
  localparam logic [3:0] JOB_BUS    = 4'd7;
  localparam logic [3:0] JOB_FREQ   = 4'd8;
  localparam logic [3:0] JOB_THREE  = 4'd9;  // select or write, ack, req/desel

  localparam logic [31:0] FREQ_RESET  = 32'd12000000;
  localparam logic [15:0] BUF_RESET   = 16'hFFFF;
  localparam logic [7:0]  BUS_RESET   = 8'h08;
  localparam logic [15:0] IFACE_RESET = 16'h0001;

  localparam logic [1:0] REG_FREQ  = 2'd0;
  localparam logic [1:0] REG_BUF   = 2'd1;
  localparam logic [1:0] REG_BUS   = 2'd2;
  localparam logic [1:0] REG_IFACE = 2'd3;

  typedef struct packed {
    logic [3:0] kind;
    logic [2:0] d0;
    logic [7:0] b0;
    logic [2:0] d1;
    logic [7:0] b1;
    logic [2:0] d2;
  } job_t;

  function automatic logic [7:0] name_rom(input logic [3:0] i);
    logic [7:0] r;
    unique case (i)
      4'd0: r = 8'h70;  4'd1: r = 8'h69;  4'd2: r = 8'h63;  4'd3: r = 8'h6F;
      4'd4: r = 8'h2D;  4'd5: r = 8'h69;  4'd6: r = 8'h63;  4'd7: r = 8'h65;
      4'd8: r = 8'h2D;  4'd9: r = 8'h73;  4'd10: r = 8'h65; 4'd11: r = 8'h72;
      4'd12: r = 8'h70; 4'd13: r = 8'h72; 4'd14: r = 8'h6F; default: r = 8'h67;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cmd_map(input logic [4:0] i);
    logic [7:0] r;
    unique case (i)
      5'd0: r = 8'h3F;
      5'd2: r = 8'h3D;
      default: r = 8'h00;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

### hw/rtl/spb_parser.sv
`default_nettype none
module spb_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          kind,
  input  wire logic [7:0]    in_byte,
  input  wire logic [7:0]    bus_mask,
  output logic               job_valid,
  input  wire logic          job_ready,
  output spb_pkg::job_t      job
);
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ARGS = 2'd1;
  localparam logic [1:0] PH_WDATA = 2'd2;
  localparam logic [1:0] PH_RWAIT = 2'd3;

  logic [1:0]  phase;
  logic [7:0]  cmd;
  logic [2:0]  argc;
  logic [23:0] wrem;
  logic [23:0] rrem;
  logic        fnz;

  logic [1:0]  phase_next;
  logic [7:0]  cmd_next;
  logic [2:0]  argc_next;
  logic [23:0] wrem_next;
  logic [23:0] rrem_next;
  logic        fnz_next;
  spb_pkg::job_t job_next;

  logic [1:0]  ph;
  logic [23:0] rdec;
  logic [23:0] wdec;
  logic [23:0] wfull;
  logic [23:0] rfull;
  logic        fire;

  // output register slot: take an item when empty or being drained
  assign in_ready = !job_valid || job_ready;
  assign fire = in_valid && in_ready;

  always_comb begin
    ph = (phase == PH_RWAIT && rrem == '0) ? PH_IDLE : phase;
    phase_next = ph;
    cmd_next = cmd;
    argc_next = argc;
    wrem_next = wrem;
    rrem_next = rrem;
    fnz_next = fnz;
    job_next = '0;
    job_next.kind = spb_pkg::JOB_NONE;
    rdec = rrem - 24'd1;
    wdec = wrem - 24'd1;
    wfull = wrem;
    rfull = rrem;
    if (kind) begin
      if (ph == PH_RWAIT) begin
        rrem_next = rdec;
        job_next.kind = spb_pkg::JOB_TWO;
        job_next.d0 = spb_pkg::DST_HOST;
        job_next.b0 = in_byte;
        job_next.d1 = (rdec != '0) ? spb_pkg::DST_REQ : spb_pkg::DST_DESEL;
        if (rdec == '0) phase_next = PH_IDLE;
      end
    end else begin
      unique case (ph)
        PH_IDLE: begin
          cmd_next = in_byte;
          job_next.kind = spb_pkg::JOB_ONE;
          job_next.d0 = spb_pkg::DST_HOST;
          job_next.b0 = spb_pkg::NAK_BYTE;
          unique case (in_byte)
            8'h00, 8'h9F: job_next.b0 = spb_pkg::ACK_BYTE;
            8'h01: job_next.kind = spb_pkg::JOB_IFACE;
            8'h02: job_next.kind = spb_pkg::JOB_MAP;
            8'h03: job_next.kind = spb_pkg::JOB_NAME;
            8'h04: job_next.kind = spb_pkg::JOB_BUF;
            8'h05: job_next.kind = spb_pkg::JOB_BUS;
            8'h10: begin
              job_next.kind = spb_pkg::JOB_TWO;
              job_next.d1 = spb_pkg::DST_HOST;
              job_next.b1 = spb_pkg::ACK_BYTE;
            end
            8'h12, 8'h13, 8'h14, 8'h15: begin
              job_next.kind = spb_pkg::JOB_NONE;
              phase_next = PH_ARGS;
              argc_next = '0;
              wrem_next = '0;
              rrem_next = '0;
              fnz_next = 1'b0;
            end
            default: ;
          endcase
        end
        PH_ARGS: begin
          unique case (cmd)
            8'h15: begin
              job_next.kind = spb_pkg::JOB_TWO;
              job_next.d0 = (in_byte != '0) ? spb_pkg::DST_HOLD : spb_pkg::DST_PULSE;
              job_next.d1 = spb_pkg::DST_HOST;
              job_next.b1 = spb_pkg::ACK_BYTE;
              phase_next = PH_IDLE;
            end
            8'h12: begin
              job_next.kind = spb_pkg::JOB_ONE;
              job_next.d0 = spb_pkg::DST_HOST;
              job_next.b0 = ((in_byte & bus_mask) != '0) ? spb_pkg::ACK_BYTE
                                                         : spb_pkg::NAK_BYTE;
              phase_next = PH_IDLE;
            end
            8'h14: begin
              argc_next = argc + 3'd1;
              if (in_byte != '0) fnz_next = 1'b1;
              if (argc_next >= 3'd4) begin
                phase_next = PH_IDLE;
                if (fnz_next) begin
                  job_next.kind = spb_pkg::JOB_FREQ;
                end else begin
                  job_next.kind = spb_pkg::JOB_ONE;
                  job_next.d0 = spb_pkg::DST_HOST;
                  job_next.b0 = spb_pkg::NAK_BYTE;
                end
              end
            end
            8'h13: begin
              unique case (argc)
                3'd0: wfull[7:0] = wrem[7:0] | in_byte;
                3'd1: wfull[15:8] = wrem[15:8] | in_byte;
                3'd2: wfull[23:16] = wrem[23:16] | in_byte;
                3'd3: rfull[7:0] = rrem[7:0] | in_byte;
                3'd4: rfull[15:8] = rrem[15:8] | in_byte;
                3'd5: rfull[23:16] = rrem[23:16] | in_byte;
                default: ;
              endcase
              wrem_next = wfull;
              rrem_next = rfull;
              argc_next = argc + 3'd1;
              if (argc_next >= 3'd6) begin
                if (wfull != '0) begin
                  job_next.kind = spb_pkg::JOB_ONE;
                  job_next.d0 = spb_pkg::DST_SEL;
                  phase_next = PH_WDATA;
                end else begin
                  job_next.kind = spb_pkg::JOB_THREE;
                  job_next.d0 = spb_pkg::DST_SEL;
                  job_next.d1 = spb_pkg::DST_HOST;
                  job_next.b1 = spb_pkg::ACK_BYTE;
                  job_next.d2 = (rfull != '0) ? spb_pkg::DST_REQ : spb_pkg::DST_DESEL;
                  phase_next = (rfull != '0) ? PH_RWAIT : PH_IDLE;
                end
              end
            end
            default: phase_next = PH_IDLE;
          endcase
        end
        PH_WDATA: begin
          wrem_next = wdec;
          if (wdec != '0) begin
            job_next.kind = spb_pkg::JOB_ONE;
            job_next.d0 = spb_pkg::DST_WRITE;
            job_next.b0 = in_byte;
          end else begin
            job_next.kind = spb_pkg::JOB_THREE;
            job_next.d0 = spb_pkg::DST_WRITE;
            job_next.b0 = in_byte;
            job_next.d1 = spb_pkg::DST_HOST;
            job_next.b1 = spb_pkg::ACK_BYTE;
            job_next.d2 = (rrem != '0) ? spb_pkg::DST_REQ : spb_pkg::DST_DESEL;
            phase_next = (rrem != '0) ? PH_RWAIT : PH_IDLE;
          end
        end
        default: ;  // host byte during read wait is dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cmd <= '0;
      argc <= '0;
      wrem <= '0;
      rrem <= '0;
      fnz <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) job_valid <= 1'b0;
      if (fire) begin
        phase <= phase_next;
        cmd <= cmd_next;
        argc <= argc_next;
        wrem <= wrem_next;
        rrem <= rrem_next;
        fnz <= fnz_next;
        job_valid <= (job_next.kind != spb_pkg::JOB_NONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) job <= job_next;
  end
endmodule
`default_nettype wire

### hw/rtl/spb_emitter.sv
`default_nettype none
module spb_emitter #(
  parameter int NAME_BYTES = spb_pkg::NAME_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire spb_pkg::job_t job,
  input  wire logic [31:0]   freq,
  input  wire logic [15:0]   buf_size,
  input  wire logic [7:0]    bus_mask,
  input  wire logic [15:0]   iface,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [2:0]         destination,
  output logic [7:0]         out_byte,
  output logic               last
);
  logic [5:0] idx;
  logic [5:0] cnt;
  logic [2:0] dst_c;
  logic [7:0] byte_c;
  logic       adv;
  logic [5:0] nm;
  logic [1:0] fsel;

  always_comb begin
    unique case (job.kind)
      spb_pkg::JOB_ONE:   cnt = 6'd1;
      spb_pkg::JOB_TWO:   cnt = 6'd2;
      spb_pkg::JOB_THREE: cnt = 6'd3;
      spb_pkg::JOB_IFACE: cnt = 6'd3;
      spb_pkg::JOB_BUF:   cnt = 6'd3;
      spb_pkg::JOB_BUS:   cnt = 6'd2;
      spb_pkg::JOB_FREQ:  cnt = 6'd5;
      spb_pkg::JOB_MAP:   cnt = 6'd33;
      spb_pkg::JOB_NAME:  cnt = 6'd17;
      default:            cnt = 6'd1;
    endcase
  end

  always_comb begin
    dst_c = spb_pkg::DST_HOST;
    byte_c = '0;
    nm = idx - 6'd1;
    // frequency bytes go out low byte first
    fsel = idx[1:0] - 2'd1;
    unique case (job.kind)
      spb_pkg::JOB_ONE: begin
        dst_c = job.d0; byte_c = job.b0;
      end
      spb_pkg::JOB_TWO, spb_pkg::JOB_THREE: begin
        priority case (idx)
          6'd0: begin dst_c = job.d0; byte_c = job.b0; end
          6'd1: begin dst_c = job.d1; byte_c = job.b1; end
          default: dst_c = job.d2;
        endcase
      end
      default: begin
        if (idx == '0) begin
          byte_c = spb_pkg::ACK_BYTE;
        end else begin
          unique case (job.kind)
            spb_pkg::JOB_IFACE: byte_c = (idx == 6'd1) ? iface[7:0] : iface[15:8];
            spb_pkg::JOB_BUF: byte_c = (idx == 6'd1) ? buf_size[7:0] : buf_size[15:8];
            spb_pkg::JOB_BUS: byte_c = bus_mask;
            spb_pkg::JOB_FREQ: byte_c = freq[{fsel, 3'b000} +: 8];
            spb_pkg::JOB_MAP: byte_c = spb_pkg::cmd_map(nm[4:0]);
            spb_pkg::JOB_NAME:
              byte_c = (32'(nm) < NAME_BYTES) ? spb_pkg::name_rom(nm[3:0]) : 8'h00;
            default: byte_c = '0;
          endcase
        end
      end
    endcase
  end

  // one result per cycle into the output register while it is empty or being drained
  assign adv = job_valid && (!out_valid || out_ready);
  assign job_ready = adv && (idx == cnt - 6'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (adv) begin
        out_valid <= 1'b1;
        idx <= job_ready ? 6'd0 : idx + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      destination <= dst_c;
      out_byte <= byte_c;
      last <= job_ready;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/serprog_spi_bridge_parser_core.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | kind, in_byte
// out     | output    | out_valid / out_ready | destination, out_byte, last
// cfg     | input     | APB psel/penable      | four registers at 4*i
// A byte is parsed combinationally and registered as a reply job; the emitter
// sends one result per cycle while the output register is not stalled.
// Long replies (command map 33, name 17) stall input while the job slot is full.
// Reset is synchronous; registers return to their documented defaults.
// out_ready low holds the output register and backs up through the job slot.
`default_nettype none
module serprog_spi_bridge_parser_core #(
  parameter int NAME_BYTES = spb_pkg::NAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       destination,
  output logic [7:0]       out_byte,
  output logic             last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [31:0] freq;
  logic [15:0] buf_size;
  logic [7:0]  bus_mask;
  logic [15:0] iface;
  logic        job_valid;
  logic        job_ready;
  spb_pkg::job_t job;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq <= spb_pkg::FREQ_RESET;
      buf_size <= spb_pkg::BUF_RESET;
      bus_mask <= spb_pkg::BUS_RESET;
      iface <= spb_pkg::IFACE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        spb_pkg::REG_FREQ:  freq <= pwdata;
        spb_pkg::REG_BUF:   buf_size <= pwdata[15:0];
        spb_pkg::REG_BUS:   bus_mask <= pwdata[7:0];
        spb_pkg::REG_IFACE: iface <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      spb_pkg::REG_FREQ:  prdata = freq;
      spb_pkg::REG_BUF:   prdata = {16'd0, buf_size};
      spb_pkg::REG_BUS:   prdata = {24'd0, bus_mask};
      spb_pkg::REG_IFACE: prdata = {16'd0, iface};
      default:            prdata = '0;
    endcase
  end

  spb_parser u_parser (
    .clk, .rst, .in_valid, .in_ready, .kind, .in_byte,
    .bus_mask, .job_valid, .job_ready, .job
  );

  spb_emitter #(.NAME_BYTES(NAME_BYTES)) u_emitter (
    .clk, .rst, .job_valid, .job_ready, .job,
    .freq, .buf_size, .bus_mask, .iface,
    .out_valid, .out_ready, .destination, .out_byte, .last
  );
endmodule
`default_nettype wire

### hw/rtl/spb_checker.sv
`default_nettype none
module spb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] destination,
  input wire logic [7:0] out_byte,
  input wire logic       pready
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(destination) && $stable(out_byte))
    else $error("output item changed while stalled");
  a_dest_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> destination != 3'd7)
    else $error("bad destination");
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && destination != 3'd0 && destination != 3'd1 |-> out_byte == 8'd0)
    else $error("control result carries data");
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind serprog_spi_bridge_parser_core spb_checker u_chk (
  .clk, .rst, .out_valid, .out_ready,
  .destination, .out_byte, .pready
);
`default_nettype wire
